// ===== sv/sv39_ptw_pkg.sv =====
package sv39_ptw_pkg;

  localparam int unsigned STORE_WORDS_DEF = 4096;
  localparam int unsigned LEVELS_DEF = 3;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned IDX_BITS = 9;
  localparam int unsigned PAGE_WORDS = 512;
  localparam int unsigned PTE_VALID_BIT = 0;
  localparam int unsigned PTE_USER_BIT = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FAULT = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic REG_ROOT_TABLE_PAGE = 1'b0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } ptw_state_e;

endpackage

// ===== sv/sv39_page_table_walker.sv =====
// Sv39 page-table walker over a local store of 64-bit entries. A write item stores one entry
// and its result (zero address, status ok) is offered in the cycle after the transfer. A
// translate item reads one entry per level from the single-ported store, with one registered
// read a cycle, and its result goes to the output register when the walk ends, or is offered
// in the cycle after the transfer when the root table lies outside the store; the walk ends
// early at the first invalid entry or out-of-store table. The block takes one item at a time
// and takes the next no earlier than the cycle in which the previous result leaves the output
// register. After reset the store is zeroed in a pass over every word during which no item
// is taken; configuration writes are taken as always.
module sv39_page_table_walker #(
  parameter int unsigned STORE_WORDS = sv39_ptw_pkg::STORE_WORDS_DEF,
  parameter int unsigned LEVELS = sv39_ptw_pkg::LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [11:0] word_index_i,
  input  logic [63:0] entry_value_i,
  input  logic [38:0] virt_addr_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] phys_addr_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned TABLE_PAGES = STORE_WORDS / sv39_ptw_pkg::PAGE_WORDS;

  sv39_ptw_pkg::ptw_state_e state_q, state_d;

  logic [2:0]    root_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    level_q, level_d;
  logic [38:0]   va_q, va_d;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   phys_q, phys_d;
  logic [1:0]    status_q, status_d;

  logic [63:0]   store_q [STORE_WORDS];
  logic [63:0]   rdata_q;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata;
  logic          done;
  logic          in_xfer, out_xfer, cfg_write;
  logic          out_free;
  logic [51:0]   next_page;
  logic          next_outside;
  logic          root_outside;
  logic [1:0]    level_dn;

  function automatic logic [8:0] va_index(logic [38:0] va, logic [1:0] lvl);
    logic [47:0] ext;
    ext = {9'b0, va};
    return ext[sv39_ptw_pkg::PAGE_SHIFT + sv39_ptw_pkg::IDX_BITS * lvl +: sv39_ptw_pkg::IDX_BITS];
  endfunction

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == sv39_ptw_pkg::REG_ROOT_TABLE_PAGE) ? {29'b0, root_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= 3'd0;
    end else if (cfg_write && paddr[2] == sv39_ptw_pkg::REG_ROOT_TABLE_PAGE) begin
      root_q <= pwdata[2:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == sv39_ptw_pkg::ST_IDLE && out_free);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;

  assign next_page = rdata_q[61:10];
  assign next_outside = {12'b0, next_page} >= 64'(TABLE_PAGES);
  assign root_outside = {29'b0, root_q} >= 32'(TABLE_PAGES);
  assign level_dn = level_q - 2'd1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sv39_ptw_pkg::ST_CLEAR: begin
        if (clr_q == AW'(STORE_WORDS - 1)) state_d = sv39_ptw_pkg::ST_IDLE;
      end
      sv39_ptw_pkg::ST_IDLE: begin
        if (in_xfer && cmd_i == sv39_ptw_pkg::CMD_TRANSLATE && !root_outside) begin
          state_d = sv39_ptw_pkg::ST_WALK;
        end
      end
      sv39_ptw_pkg::ST_WALK: begin
        if (done) state_d = sv39_ptw_pkg::ST_IDLE;
      end
      default: state_d = sv39_ptw_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = clr_q;
    wdata = 64'b0;
    re = 1'b0;
    raddr = AW'({root_q, va_index(virt_addr_i, 2'(LEVELS - 1))});
    clr_d = clr_q;
    level_d = level_q;
    va_d = va_q;
    done = 1'b0;
    phys_d = phys_q;
    status_d = status_q;
    out_valid_d = out_valid_q && !out_xfer;
    case (state_q)
      sv39_ptw_pkg::ST_CLEAR: begin
        we = 1'b1;
        clr_d = clr_q + AW'(1);
      end
      sv39_ptw_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (cmd_i == sv39_ptw_pkg::CMD_WRITE) begin
            we = {20'b0, word_index_i} < 32'(STORE_WORDS);
            waddr = AW'(word_index_i);
            wdata = entry_value_i;
            out_valid_d = 1'b1;
            phys_d = 64'b0;
            status_d = sv39_ptw_pkg::STATUS_OK;
          end else if (root_outside) begin
            out_valid_d = 1'b1;
            phys_d = 64'b0;
            status_d = sv39_ptw_pkg::STATUS_OUTSIDE;
          end else begin
            re = 1'b1;
            va_d = virt_addr_i;
            level_d = 2'(LEVELS - 1);
          end
        end
      end
      sv39_ptw_pkg::ST_WALK: begin
        phys_d = 64'b0;
        if (level_q != 2'd0) begin
          if (!rdata_q[sv39_ptw_pkg::PTE_VALID_BIT]) begin
            done = 1'b1;
            status_d = sv39_ptw_pkg::STATUS_FAULT;
          end else if (next_outside) begin
            done = 1'b1;
            status_d = sv39_ptw_pkg::STATUS_OUTSIDE;
          end else begin
            re = 1'b1;
            raddr = AW'({next_page, va_index(va_q, level_dn)});
            level_d = level_dn;
          end
        end else begin
          done = 1'b1;
          if (rdata_q[sv39_ptw_pkg::PTE_VALID_BIT] && rdata_q[sv39_ptw_pkg::PTE_USER_BIT]) begin
            phys_d = {next_page, 12'b0};
            status_d = sv39_ptw_pkg::STATUS_OK;
          end else begin
            status_d = sv39_ptw_pkg::STATUS_FAULT;
          end
        end
        if (done) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) store_q[waddr] <= wdata;
    if (re) rdata_q <= store_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sv39_ptw_pkg::ST_CLEAR;
      clr_q <= '0;
      level_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      level_q <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q <= va_d;
    phys_q <= phys_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign phys_addr_o = phys_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sv39_ptw_pkg::ST_CLEAR |-> !out_valid_q)
    else $error("result offered during store clearing");

  a_walk_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sv39_ptw_pkg::ST_WALK |-> level_q <= 2'(LEVELS - 1))
    else $error("walk level beyond top level");

  a_fault_has_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != sv39_ptw_pkg::STATUS_OK |-> phys_q == 64'b0)
    else $error("faulting result carries an address");

  a_walk_ends_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sv39_ptw_pkg::ST_WALK |-> !out_valid_q)
    else $error("walk running while a result is pending");
`endif

endmodule

// ===== test/sv39_page_table_walker_checker.sv =====
`timescale 1ns / 100ps

module sv39_page_table_walker_checker (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        cmd_i,
  input  logic [11:0] word_index_i,
  input  logic [63:0] entry_value_i,
  input  logic [38:0] virt_addr_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] phys_addr_i,
  input  logic [1:0]  status_i,

  output int          fail_count_o,
  output int          pending_o,
  output int          write_count_o,
  output int          ok_count_o,
  output int          fault_count_o,
  output int          outside_count_o
);

  localparam int unsigned TABLE_PAGES =
    sv39_ptw_pkg::STORE_WORDS_DEF / sv39_ptw_pkg::PAGE_WORDS;
  localparam int unsigned PPN_LSB = 10;
  localparam int unsigned PPN_BITS = 64 - sv39_ptw_pkg::PAGE_SHIFT;
  localparam logic [2:0] ROOT_ADDR = {sv39_ptw_pkg::REG_ROOT_TABLE_PAGE, 2'b00};

  typedef struct packed {
    logic [63:0] phys_addr;
    logic [1:0]  status;
  } walk_result_t;

  logic [63:0]  table_words [sv39_ptw_pkg::STORE_WORDS_DEF];
  logic [2:0]   root_page;
  walk_result_t expected_q [$];
  walk_result_t want;

  function automatic walk_result_t walk_tables(input logic [38:0] va);
    walk_result_t        res;
    logic [PPN_BITS-1:0] page;
    logic [63:0]         pte;
    logic [8:0]          idx;
    res = '0;
    page = PPN_BITS'(root_page);
    for (int lvl = sv39_ptw_pkg::LEVELS_DEF - 1; lvl >= 0; lvl--) begin
      if (page >= TABLE_PAGES) begin
        res.status = sv39_ptw_pkg::STATUS_OUTSIDE;
        return res;
      end
      idx = va[sv39_ptw_pkg::PAGE_SHIFT + sv39_ptw_pkg::IDX_BITS * lvl +: sv39_ptw_pkg::IDX_BITS];
      pte = table_words[page * sv39_ptw_pkg::PAGE_WORDS + idx];
      if (!pte[sv39_ptw_pkg::PTE_VALID_BIT] ||
          (lvl == 0 && !pte[sv39_ptw_pkg::PTE_USER_BIT])) begin
        res.status = sv39_ptw_pkg::STATUS_FAULT;
        return res;
      end
      page = pte[PPN_LSB +: PPN_BITS];
    end
    res.phys_addr = {page, {sv39_ptw_pkg::PAGE_SHIFT{1'b0}}};
    res.status = sv39_ptw_pkg::STATUS_OK;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (table_words[i]) table_words[i] = '0;
      root_page = '0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      write_count_o = 0;
      ok_count_o = 0;
      fault_count_o = 0;
      outside_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, got phys_addr %h status %0d",
                   $time, phys_addr_i, status_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (phys_addr_i !== want.phys_addr) begin
            $display("%0t: phys_addr mismatch: expected %h, got %h",
                     $time, want.phys_addr, phys_addr_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, status_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == sv39_ptw_pkg::CMD_WRITE) begin
          if (word_index_i < sv39_ptw_pkg::STORE_WORDS_DEF) begin
            table_words[word_index_i] = entry_value_i;
          end
          expected_q.push_back('0);
          write_count_o++;
        end else begin
          want = walk_tables(virt_addr_i);
          expected_q.push_back(want);
          case (want.status)
            sv39_ptw_pkg::STATUS_OK:    ok_count_o++;
            sv39_ptw_pkg::STATUS_FAULT: fault_count_o++;
            default:                    outside_count_o++;
          endcase
        end
      end
      if (psel && penable && pwrite && pready && paddr == ROOT_ADDR) begin
        root_page = pwdata[2:0];
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== test/sv39_page_table_walker_tb.sv =====
`timescale 1ns / 100ps

module sv39_page_table_walker_tb;

  localparam logic [2:0] ROOT_ADDR = {sv39_ptw_pkg::REG_ROOT_TABLE_PAGE, 2'b00};
  localparam int TOTAL_ITEMS = 1400;
  localparam int QUIET_AFTER = 1200;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [11:0] word_index;
  logic [63:0] entry_value;
  logic [38:0] virt_addr;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] phys_addr;
  logic [1:0]  status;

  int         fail_count;
  int         pending;
  int         write_count;
  int         ok_count;
  int         fault_count;
  int         outside_count;
  int         items_sent;
  int         quiet_cycles;
  int         stall_left;
  int         phase;
  bit         idle_on;
  logic [2:0] root_page;

  sv39_page_table_walker dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .word_index_i (word_index),
    .entry_value_i(entry_value),
    .virt_addr_i  (virt_addr),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .phys_addr_o  (phys_addr),
    .status_o     (status)
  );

  sv39_page_table_walker_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .cmd_i          (cmd),
    .word_index_i   (word_index),
    .entry_value_i  (entry_value),
    .virt_addr_i    (virt_addr),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .phys_addr_i    (phys_addr),
    .status_i       (status),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .write_count_o  (write_count),
    .ok_count_o     (ok_count),
    .fault_count_o  (fault_count),
    .outside_count_o(outside_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending);
        $display("FAIL sv39_page_table_walker");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic logic [38:0] rand_va();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[38:0];
  endfunction

  function automatic logic [51:0] rand_ppn();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[51:0];
  endfunction

  function automatic logic [51:0] outside_ppn();
    logic [51:0] p;
    p = rand_ppn();
    if ($urandom_range(0, 1)) p = 52'($urandom_range(8, 511));
    if (p[51:3] == '0) p[3] = 1'b1;
    return p;
  endfunction

  function automatic logic [63:0] make_pte(input logic [51:0] ppn, input logic valid,
                                           input logic user);
    logic [63:0] e;
    e = {$urandom, $urandom};
    e[61:10] = ppn;
    e[sv39_ptw_pkg::PTE_VALID_BIT] = valid;
    e[sv39_ptw_pkg::PTE_USER_BIT] = user;
    return e;
  endfunction

  task automatic issue_command(input logic c, input logic [11:0] widx, input logic [63:0] val,
                               input logic [38:0] va);
    @(negedge clk);
    in_valid = 1'b1;
    cmd = c;
    word_index = widx;
    entry_value = val;
    virt_addr = va;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_word(input logic [11:0] widx, input logic [63:0] val);
    issue_command(sv39_ptw_pkg::CMD_WRITE, widx, val, rand_va());
  endtask

  task automatic translate_va(input logic [38:0] va);
    issue_command(sv39_ptw_pkg::CMD_TRANSLATE, 12'($urandom), {$urandom, $urandom}, va);
  endtask

  task automatic map_walk(input logic [38:0] va, input logic [2:0] root, input logic [2:0] p1,
                          input logic [2:0] p0, input logic [63:0] top_pte,
                          input logic [63:0] mid_pte, input logic [63:0] leaf_pte);
    write_word({root, va[38:30]}, top_pte);
    write_word({p1, va[29:21]}, mid_pte);
    write_word({p0, va[20:12]}, leaf_pte);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_root(input logic [2:0] page);
    drain_results();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ROOT_ADDR;
    pwdata = 32'(page);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    root_page = page;
  endtask

  initial begin
    logic [38:0] va;
    logic [38:0] va2;
    logic [38:0] last_va;
    logic [63:0] pte;
    logic [2:0]  p1;
    logic [2:0]  p0;
    int          pick;
    int          next_phase_at;

    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cmd = sv39_ptw_pkg::CMD_WRITE;
    word_index = '0;
    entry_value = '0;
    virt_addr = '0;
    out_stall = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    stall_left = 0;
    phase = 0;
    idle_on = 1'b1;
    root_page = '0;
    last_va = '0;

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    set_root(3'd0);

    va = {9'h1A5, 9'h0C3, 9'h1FF, 12'hABC};
    translate_va(va);
    pte = make_pte(52'd3, 1'b1, 1'b0);
    pte[63:62] = 2'b11;
    map_walk(va, 3'd0, 3'd3, 3'd5, pte, make_pte(52'd5, 1'b1, 1'b0),
             make_pte('1, 1'b1, 1'b1));
    translate_va(va);
    write_word({3'd5, va[20:12]}, make_pte('0, 1'b1, 1'b1));
    translate_va(va);
    write_word({3'd5, va[20:12]}, make_pte(52'h1234, 1'b1, 1'b0));
    translate_va(va);
    write_word({3'd5, va[20:12]}, make_pte(52'h1234, 1'b0, 1'b1));
    translate_va(va);
    write_word({3'd3, va[29:21]}, make_pte(52'd8, 1'b1, 1'b0));
    translate_va(va);
    write_word({3'd0, va[38:30]}, make_pte('1, 1'b1, 1'b0));
    translate_va(va);
    write_word({3'd0, va[38:30]}, make_pte(52'd3, 1'b0, 1'b1));
    translate_va(va);
    write_word(12'hFFF, '1);
    write_word(12'h000, '0);
    translate_va('1);
    translate_va('0);

    next_phase_at = items_sent;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= next_phase_at) begin
        set_root(phase == 0 ? 3'd7 : phase == 1 ? 3'd0 : 3'($urandom_range(0, 7)));
        idle_on = (items_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
        phase++;
        next_phase_at = items_sent + $urandom_range(120, 220);
      end
      if (items_sent >= QUIET_AFTER) idle_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        va = rand_va();
        p1 = 3'($urandom_range(0, 7));
        p0 = 3'($urandom_range(0, 7));
        map_walk(va, root_page, p1, p0,
                 make_pte($urandom_range(0, 15) == 0 ? outside_ppn() : 52'(p1),
                          $urandom_range(0, 15) != 0, 1'($urandom_range(0, 1))),
                 make_pte($urandom_range(0, 15) == 0 ? outside_ppn() : 52'(p0),
                          $urandom_range(0, 15) != 0, 1'($urandom_range(0, 1))),
                 make_pte($urandom_range(0, 15) == 0 ? 52'd0 : rand_ppn(),
                          $urandom_range(0, 15) != 0, $urandom_range(0, 7) != 0));
        translate_va(va);
        if ($urandom_range(0, 1)) begin
          va2 = rand_va();
          translate_va({va[38:12], va2[11:0]});
        end
        last_va = va;
      end else if (pick < 8) begin
        write_word(12'($urandom), {$urandom, $urandom});
      end else begin
        va2 = rand_va();
        if ($urandom_range(0, 1)) va2[38:21] = last_va[38:21];
        translate_va(va2);
      end
    end

    idle_on = 1'b0;
    drain_results();
    repeat (10) @(negedge clk);

    $display("%0d items: %0d entry writes, %0d walks ok, %0d faulted, %0d hit a table outside",
             items_sent, write_count, ok_count, fault_count, outside_count);
    $display("root table moved through %0d settings incl. pages 0 and 7, with bursty stalls",
             phase + 1);
    if (fail_count == 0) begin
      $display("PASS sv39_page_table_walker");
    end else begin
      $display("FAIL sv39_page_table_walker");
    end
    $finish;
  end

endmodule
